### rtl/qcs_pkg.sv
// qcs_pkg: shared widths, payload structs and register codes for the
// quad corner sort and square test block; no dependencies
`timescale 1ns / 1ps

package qcs_pkg;

  // coordinate width and derived arithmetic widths
  localparam int COORD_BITS = 12;
  localparam int DIFF_W     = COORD_BITS + 1;      // signed edge component
  localparam int SQ_W       = 2 * COORD_BITS;      // one squared component
  localparam int SIDE_W     = 2 * COORD_BITS + 1;  // squared side length, |dot|
  localparam int XP_W       = 2 * DIFF_W;          // signed component product
  localparam int PROD_W     = 2 * SIDE_W;          // dot^2 or la*lb
  localparam int LO_W       = SIDE_W;              // low split of la*lb
  localparam int HI_W       = PROD_W - LO_W;       // high split of la*lb

  // configuration registers
  localparam int MIN_SIDE_W = 25;
  localparam int MAX_COS_W  = 17;
  localparam logic [MIN_SIDE_W-1:0] MIN_SIDE_RST = MIN_SIDE_W'(22500);
  localparam logic [MAX_COS_W-1:0]  MAX_COS_RST  = MAX_COS_W'(5898);
  localparam int COS_SHIFT  = 16;                  // Q1.16 scaling of dot^2
  localparam int MUL_W      = MAX_COS_W + LO_W;
  localparam int RHS_W      = MAX_COS_W + PROD_W;

  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  typedef enum logic [0:0] {
    REG_MIN_SIDE = 1'b0,
    REG_MAX_COS  = 1'b1
  } reg_idx_e;

  typedef struct packed {
    logic [MIN_SIDE_W-1:0] min_side_sq;
    logic [MAX_COS_W-1:0]  max_cos_sq;
  } cfg_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] p0_x;
    logic [COORD_BITS-1:0] p0_y;
    logic [COORD_BITS-1:0] p1_x;
    logic [COORD_BITS-1:0] p1_y;
    logic [COORD_BITS-1:0] p2_x;
    logic [COORD_BITS-1:0] p2_y;
    logic [COORD_BITS-1:0] p3_x;
    logic [COORD_BITS-1:0] p3_y;
  } in_item_t;

  typedef struct packed {
    logic                  is_square;
    logic [COORD_BITS-1:0] tl_x;
    logic [COORD_BITS-1:0] tl_y;
    logic [COORD_BITS-1:0] tr_x;
    logic [COORD_BITS-1:0] tr_y;
    logic [COORD_BITS-1:0] br_x;
    logic [COORD_BITS-1:0] br_y;
    logic [COORD_BITS-1:0] bl_x;
    logic [COORD_BITS-1:0] bl_y;
  } out_item_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
  } point_t;

  // ordered corners, index 0 tl, 1 tr, 2 br, 3 bl
  typedef point_t [3:0] quad_t;

  // geometry stage output, side i runs from corner i to corner i+1
  typedef struct packed {
    quad_t                  quad;
    logic [3:0][SIDE_W-1:0] side;
    logic [3:0][SIDE_W-1:0] ad;
    logic [3:0]             side_ok;
  } geom_t;

endpackage

### rtl/qcs_cfg.sv
// qcs_cfg: apb register file for the side and cosine limits
// depends on qcs_pkg
`timescale 1ns / 1ps

module qcs_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qcs_pkg::ADDR_W-1:0] paddr,
  input  logic [qcs_pkg::DATA_W-1:0] pwdata,
  output logic [qcs_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output qcs_pkg::cfg_t              cfg_o
);
  import qcs_pkg::*;

  logic [MIN_SIDE_W-1:0] min_side_q, min_side_d;
  logic [MAX_COS_W-1:0]  max_cos_q, max_cos_d;
  reg_idx_e              idx;
  logic                  wr_en;

  assign idx    = reg_idx_e'(paddr[2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign pready = 1'b1;

  always_comb begin
    min_side_d = min_side_q;
    max_cos_d  = max_cos_q;
    if (wr_en) begin
      case (idx)
        REG_MIN_SIDE: min_side_d = pwdata[MIN_SIDE_W-1:0];
        REG_MAX_COS:  max_cos_d  = pwdata[MAX_COS_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN_SIDE: prdata = DATA_W'(min_side_q);
      REG_MAX_COS:  prdata = DATA_W'(max_cos_q);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_side_q <= MIN_SIDE_RST;
      max_cos_q  <= MAX_COS_RST;
    end else begin
      min_side_q <= min_side_d;
      max_cos_q  <= max_cos_d;
    end
  end

  assign cfg_o.min_side_sq = min_side_q;
  assign cfg_o.max_cos_sq  = max_cos_q;

endmodule

### rtl/qcs_sort.sv
// qcs_sort: first pipeline stage, orders the four corners tl, tr, br, bl
// depends on qcs_pkg
`timescale 1ns / 1ps

module qcs_sort (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  qcs_pkg::in_item_t item_i,
  output logic              valid_o,
  output qcs_pkg::quad_t    quad_o
);
  import qcs_pkg::*;

  point_t     p [4];
  point_t     top0, top1, bot0, bot1;
  logic [1:0] hi1, hi2;
  logic       found, taken;
  quad_t      quad_d, quad_q;
  logic       valid_q;

  assign p[0] = '{x: item_i.p0_x, y: item_i.p0_y};
  assign p[1] = '{x: item_i.p1_x, y: item_i.p1_y};
  assign p[2] = '{x: item_i.p2_x, y: item_i.p2_y};
  assign p[3] = '{x: item_i.p3_x, y: item_i.p3_y};

  always_comb begin
    // largest y, lowest index wins ties
    hi1 = 2'd0;
    for (int i = 1; i < 4; i++) begin
      if (p[i].y > p[hi1].y) hi1 = 2'(i);
    end
    // second largest among the rest
    hi2   = 2'd0;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) != hi1) begin
        if (!found || p[i].y > p[hi2].y) begin
          hi2   = 2'(i);
          found = 1'b1;
        end
      end
    end
    // remaining two in input order
    top0  = p[0];
    top1  = p[0];
    taken = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (2'(i) != hi1 && 2'(i) != hi2) begin
        if (!taken) begin
          top0  = p[i];
          taken = 1'b1;
        end else begin
          top1 = p[i];
        end
      end
    end
    bot0 = p[hi1];
    bot1 = p[hi2];
    // split each pair by x, first of the pair is left on a tie
    quad_d[0] = (top0.x > top1.x) ? top1 : top0;
    quad_d[1] = (top0.x > top1.x) ? top0 : top1;
    quad_d[2] = (bot0.x > bot1.x) ? bot0 : bot1;
    quad_d[3] = (bot0.x > bot1.x) ? bot1 : bot0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) valid_q <= 1'b0;
    else         valid_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    quad_q <= quad_d;
  end

  assign valid_o = valid_q;
  assign quad_o  = quad_q;

endmodule

### rtl/qcs_geom.sv
// qcs_geom: edge products and their sums, side lengths and |dot| per corner
// depends on qcs_pkg
`timescale 1ns / 1ps

module qcs_geom (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  qcs_pkg::quad_t                    quad_i,
  input  logic [qcs_pkg::MIN_SIDE_W-1:0]    min_side_i,
  output logic                              valid_o,
  output qcs_pkg::geom_t                    geom_o
);
  import qcs_pkg::*;

  localparam int CMP_W = (SIDE_W > MIN_SIDE_W) ? SIDE_W : MIN_SIDE_W;

  logic signed [DIFF_W-1:0] ex [4];
  logic signed [DIFF_W-1:0] ey [4];
  logic signed [XP_W-1:0]   sqx_full [4];
  logic signed [XP_W-1:0]   sqy_full [4];

  logic [3:0][SQ_W-1:0]   sqx_d, sqx_q, sqy_d, sqy_q;
  logic [3:0][XP_W-1:0]   px_d, px_q, py_d, py_q;
  quad_t                  quad2_q;
  logic                   v2_q, v3_q;

  logic signed [XP_W-1:0] dot [4];
  logic [XP_W-1:0]        dot_abs [4];
  geom_t                  geom_d, geom_q;

  // stage 2: edge vectors and component products
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ex[i] = $signed({1'b0, quad_i[(i + 1) & 3].x}) - $signed({1'b0, quad_i[i].x});
      ey[i] = $signed({1'b0, quad_i[(i + 1) & 3].y}) - $signed({1'b0, quad_i[i].y});
    end
    for (int i = 0; i < 4; i++) begin
      sqx_full[i] = ex[i] * ex[i];
      sqy_full[i] = ey[i] * ey[i];
      sqx_d[i]    = sqx_full[i][SQ_W-1:0];
      sqy_d[i]    = sqy_full[i][SQ_W-1:0];
      // corner i sits between edge i-1 and edge i
      px_d[i]     = ex[(i + 3) & 3] * ex[i];
      py_d[i]     = ey[(i + 3) & 3] * ey[i];
    end
  end

  // stage 3: sums, absolute dot and side test
  always_comb begin
    geom_d.quad = quad2_q;
    for (int i = 0; i < 4; i++) begin
      geom_d.side[i]    = {1'b0, sqx_q[i]} + {1'b0, sqy_q[i]};
      dot[i]            = $signed(px_q[i]) + $signed(py_q[i]);
      dot_abs[i]        = dot[i][XP_W-1] ? XP_W'(-dot[i]) : XP_W'(dot[i]);
      geom_d.ad[i]      = dot_abs[i][SIDE_W-1:0];
      geom_d.side_ok[i] = CMP_W'(geom_d.side[i]) > CMP_W'(min_side_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v2_q <= valid_i;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    quad2_q <= quad_i;
    sqx_q   <= sqx_d;
    sqy_q   <= sqy_d;
    px_q    <= px_d;
    py_q    <= py_d;
    geom_q  <= geom_d;
  end

  assign valid_o = v3_q;
  assign geom_o  = geom_q;

endmodule

### rtl/qcs_cmp.sv
// qcs_cmp: squared products, limit scaling and the per-corner cosine compare
// depends on qcs_pkg
`timescale 1ns / 1ps

module qcs_cmp (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            valid_i,
  input  qcs_pkg::geom_t                  geom_i,
  input  logic [qcs_pkg::MAX_COS_W-1:0]   max_cos_i,
  output logic                            valid_o,
  output qcs_pkg::out_item_t              res_o
);
  import qcs_pkg::*;

  // stage 4
  logic [3:0][PROD_W-1:0] asq4_d, asq4_q, lp_d, lp_q;
  logic [3:0]             sok4_q;
  quad_t                  quad4_q;
  // stage 5
  logic [3:0][MUL_W-1:0]  mlo_d, mlo_q, mhi_d, mhi_q;
  logic [3:0][PROD_W-1:0] asq5_q;
  logic [3:0]             sok5_q;
  quad_t                  quad5_q;
  // stage 6
  logic [RHS_W-1:0]       rhs [4];
  logic [RHS_W-1:0]       lhs [4];
  logic [3:0]             cok;
  out_item_t              res_d, res_q;
  logic                   v4_q, v5_q, v6_q;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      asq4_d[i] = PROD_W'(geom_i.ad[i]) * PROD_W'(geom_i.ad[i]);
      lp_d[i]   = PROD_W'(geom_i.side[(i + 3) & 3]) * PROD_W'(geom_i.side[i]);
    end
  end

  // limit times la*lb in two halves
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mlo_d[i] = MUL_W'(max_cos_i) * MUL_W'(lp_q[i][LO_W-1:0]);
      mhi_d[i] = MUL_W'(max_cos_i) * MUL_W'(lp_q[i][PROD_W-1:LO_W]);
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rhs[i] = (RHS_W'(mhi_q[i]) << LO_W) + RHS_W'(mlo_q[i]);
      lhs[i] = RHS_W'({asq5_q[i], {COS_SHIFT{1'b0}}});
      cok[i] = lhs[i] < rhs[i];
    end
    res_d.is_square = (&sok5_q) & (&cok);
    res_d.tl_x      = quad5_q[0].x;
    res_d.tl_y      = quad5_q[0].y;
    res_d.tr_x      = quad5_q[1].x;
    res_d.tr_y      = quad5_q[1].y;
    res_d.br_x      = quad5_q[2].x;
    res_d.br_y      = quad5_q[2].y;
    res_d.bl_x      = quad5_q[3].x;
    res_d.bl_y      = quad5_q[3].y;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      v4_q <= valid_i;
      v5_q <= v4_q;
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    asq4_q  <= asq4_d;
    lp_q    <= lp_d;
    sok4_q  <= geom_i.side_ok;
    quad4_q <= geom_i.quad;
    mlo_q   <= mlo_d;
    mhi_q   <= mhi_d;
    asq5_q  <= asq4_q;
    sok5_q  <= sok4_q;
    quad5_q <= quad4_q;
    res_q   <= res_d;
  end

  assign valid_o = v6_q;
  assign res_o   = res_q;

endmodule

### rtl/quad_corner_sort_and_square_test.sv
// quad_corner_sort_and_square_test: top level, corner ordering and rectangle test
// depends on qcs_pkg, qcs_cfg, qcs_sort, qcs_geom, qcs_cmp
`timescale 1ns / 1ps

// channel   direction  handshake                     payload
// command   in         start, busy                   item_i (in_item_t)
// result    out        res_valid_o (one-cycle pulse)  res_o (out_item_t)
// config    in/out     psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one item enters per clock; busy stays low, so start is taken every cycle
// each result follows its item through sort, edge products,
// sums and side test, squared products, limit scaling, compare and output
// register, one stage each, all moving together every cycle
// reset clears the stage valid bits and loads the two limit registers
// the receiver cannot stall, so nothing in the pipeline ever holds

module quad_corner_sort_and_square_test (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // command side
  input  logic                       start,
  output logic                       busy,
  input  qcs_pkg::in_item_t          item_i,
  // result side
  output logic                       res_valid_o,
  output qcs_pkg::out_item_t         res_o,
  // apb configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qcs_pkg::ADDR_W-1:0] paddr,
  input  logic [qcs_pkg::DATA_W-1:0] pwdata,
  output logic [qcs_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);
  import qcs_pkg::*;

  cfg_t  cfg;
  logic  s1_valid, s3_valid;
  quad_t s1_quad;
  geom_t s3_geom;
  logic  accept;

  // fully pipelined, never refuses an item
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  qcs_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // stage 1: pick the bottom pair by y and split both pairs by x
  qcs_sort u_sort (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .item_i  (item_i),
    .valid_o (s1_valid),
    .quad_o  (s1_quad)
  );

  // stages 2 and 3: edges, squared sides, corner dot products
  qcs_geom u_geom (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (s1_valid),
    .quad_i     (s1_quad),
    .min_side_i (cfg.min_side_sq),
    .valid_o    (s3_valid),
    .geom_o     (s3_geom)
  );

  // stages 4 to 6: dot^2 * 65536 against limit * la * lb per corner
  qcs_cmp u_cmp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (s3_valid),
    .geom_i    (s3_geom),
    .max_cos_i (cfg.max_cos_sq),
    .valid_o   (res_valid_o),
    .res_o     (res_o)
  );

  // every accepted item comes out of the pipeline as a result
  a_latency_fwd : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##6 res_valid_o)
    else $error("accepted item did not produce a result");

  // no result without a matching accepted item
  a_latency_back : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> $past(accept, 6))
    else $error("result without a matching item");

  // ordered corners: top pair above bottom pair, left of right in each pair
  a_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.tl_y <= res_o.bl_y) && (res_o.tl_y <= res_o.br_y) &&
                    (res_o.tr_y <= res_o.bl_y) && (res_o.tr_y <= res_o.br_y) &&
                    (res_o.tl_x <= res_o.tr_x) && (res_o.bl_x <= res_o.br_x))
    else $error("corner ordering broken");

endmodule

### test/quad_corner_sort_and_square_test_tb.sv
// quad_corner_sort_and_square_test_tb: self-checking bench for the corner ordering and
// rectangle test block; depends on qcs_pkg and the block's rtl
`timescale 1ns / 1ps

module quad_corner_sort_and_square_test_tb;
  import qcs_pkg::*;

  // six pipeline stages between an accepted item and its result
  localparam int LATENCY   = 6;
  // cycles without any accepted item or result before the run is called hung
  localparam int STALL_MAX = 2000;

  // holds the limit copies and the queue of ordered corners still owed by the block
  class corner_scoreboard;
    longint    min_side;
    longint    max_cos;
    out_item_t due_q[$];
    int        errors;
    int        checked;

    function new();
      min_side = MIN_SIDE_RST;
      max_cos  = MAX_COS_RST;
      errors   = 0;
      checked  = 0;
    endfunction

    function void report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endfunction

    // register write as the block keeps it: only the low bits of each width
    function void set_limit(reg_idx_e idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_MIN_SIDE: min_side = value[MIN_SIDE_W-1:0];
        REG_MAX_COS:  max_cos  = value[MAX_COS_W-1:0];
        default: ;
      endcase
    endfunction

    function logic [DATA_W-1:0] limit_value(reg_idx_e idx);
      case (idx)
        REG_MIN_SIDE: return DATA_W'(min_side);
        REG_MAX_COS:  return DATA_W'(max_cos);
        default:      return '0;
      endcase
    endfunction

    // orders the four corners and judges sides and angles with exact integers
    function out_item_t order_and_judge(in_item_t it);
      longint       px[4], py[4], qx[4], qy[4];
      int           ord[4];
      int           top[2];
      int           hi1, hi2, nt, pa, pb;
      longint       dx1, dy1, dx2, dy2, dot, adot, la, lb;
      logic [127:0] lhs, rhs;
      bit           pass, corner_ok;
      out_item_t    r;
      px[0] = it.p0_x; py[0] = it.p0_y;
      px[1] = it.p1_x; py[1] = it.p1_y;
      px[2] = it.p2_x; py[2] = it.p2_y;
      px[3] = it.p3_x; py[3] = it.p3_y;
      // largest y, lowest index on ties
      hi1 = 0;
      for (int i = 1; i < 4; i++) if (py[i] > py[hi1]) hi1 = i;
      // second largest y among the rest, again lowest index on ties
      hi2 = -1;
      for (int i = 0; i < 4; i++)
        if (i != hi1 && (hi2 < 0 || py[i] > py[hi2])) hi2 = i;
      // the two others form the top pair in input order
      nt = 0;
      for (int i = 0; i < 4; i++)
        if (i != hi1 && i != hi2) begin
          top[nt] = i;
          nt++;
        end
      // smaller x is left, first of the pair wins on equal x
      ord[0] = (px[top[0]] > px[top[1]]) ? top[1] : top[0];
      ord[1] = (px[top[0]] > px[top[1]]) ? top[0] : top[1];
      ord[2] = (px[hi1] > px[hi2]) ? hi1 : hi2;
      ord[3] = (px[hi1] > px[hi2]) ? hi2 : hi1;
      for (int k = 0; k < 4; k++) begin
        qx[k] = px[ord[k]];
        qy[k] = py[ord[k]];
      end
      pass = 1'b1;
      // side k runs from corner k to corner k+1, must strictly exceed the limit
      for (int k = 0; k < 4; k++) begin
        dx1 = qx[k] - qx[(k + 1) % 4];
        dy1 = qy[k] - qy[(k + 1) % 4];
        if (!(dx1 * dx1 + dy1 * dy1 > min_side)) pass = 1'b0;
      end
      // corner k against its previous and next neighbors
      for (int k = 0; k < 4; k++) begin
        pa   = (k + 3) % 4;
        pb   = (k + 1) % 4;
        dx1  = qx[pa] - qx[k];
        dy1  = qy[pa] - qy[k];
        dx2  = qx[pb] - qx[k];
        dy2  = qy[pb] - qy[k];
        dot  = dx1 * dx2 + dy1 * dy2;
        adot = (dot < 0) ? -dot : dot;
        la   = dx1 * dx1 + dy1 * dy1;
        lb   = dx2 * dx2 + dy2 * dy2;
        if (adot == 0) begin
          // right angle passes whenever the limit is nonzero
          corner_ok = (max_cos > 0);
        end else begin
          lhs = adot;
          lhs = (lhs * lhs) << COS_SHIFT;
          rhs = max_cos;
          rhs = rhs * la;
          rhs = rhs * lb;
          corner_ok = (lhs < rhs);
        end
        if (!corner_ok) pass = 1'b0;
      end
      r           = '0;
      r.is_square = pass;
      r.tl_x = qx[0][COORD_BITS-1:0]; r.tl_y = qy[0][COORD_BITS-1:0];
      r.tr_x = qx[1][COORD_BITS-1:0]; r.tr_y = qy[1][COORD_BITS-1:0];
      r.br_x = qx[2][COORD_BITS-1:0]; r.br_y = qy[2][COORD_BITS-1:0];
      r.bl_x = qx[3][COORD_BITS-1:0]; r.bl_y = qy[3][COORD_BITS-1:0];
      return r;
    endfunction

    function void note_item(in_item_t it);
      due_q.insert(due_q.size(), order_and_judge(it));
    endfunction

    function void note_field(ref string bad, input string name,
                             input logic [COORD_BITS-1:0] got, exp);
      if (got !== exp) bad = {bad, " ", name};
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp;
      string     bad;
      if (due_q.size() == 0) begin
        report($sformatf("result %h with no item outstanding", got));
        return;
      end
      exp = due_q.pop_front();
      bad = "";
      note_field(bad, "is_square", COORD_BITS'(got.is_square), COORD_BITS'(exp.is_square));
      note_field(bad, "tl_x", got.tl_x, exp.tl_x);
      note_field(bad, "tl_y", got.tl_y, exp.tl_y);
      note_field(bad, "tr_x", got.tr_x, exp.tr_x);
      note_field(bad, "tr_y", got.tr_y, exp.tr_y);
      note_field(bad, "br_x", got.br_x, exp.br_x);
      note_field(bad, "br_y", got.br_y, exp.br_y);
      note_field(bad, "bl_x", got.bl_x, exp.bl_x);
      note_field(bad, "bl_y", got.bl_y, exp.bl_y);
      if (bad != "")
        report($sformatf("result %0d:%s differ, got %h expected %h", checked, bad, got, exp));
      checked++;
    endfunction

    function void finish_check();
      if (due_q.size() != 0) report($sformatf("%0d results never arrived", due_q.size()));
    endfunction
  endclass

  // all block inputs start at known values
  logic              clk_i   = 1'b0;
  logic              rst_ni  = 1'b0;
  logic              start   = 1'b0;
  logic              busy;
  in_item_t          item_i  = '0;
  logic              res_valid_o;
  out_item_t         res_o;
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  corner_scoreboard board = new();
  int unsigned      quiet_cycles = 0;

  quad_corner_sort_and_square_test dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // results are one-cycle pulses, taken at the edge that ends them
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) board.check_result(res_o);
  end

  // hang detector: any accepted item or result clears the count
  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || res_valid_o === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_MAX) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic in_item_t quad(int x0, y0, x1, y1, x2, y2, x3, y3);
    in_item_t it;
    it.p0_x = COORD_BITS'(x0); it.p0_y = COORD_BITS'(y0);
    it.p1_x = COORD_BITS'(x1); it.p1_y = COORD_BITS'(y1);
    it.p2_x = COORD_BITS'(x2); it.p2_y = COORD_BITS'(y2);
    it.p3_x = COORD_BITS'(x3); it.p3_y = COORD_BITS'(y3);
    return it;
  endfunction

  // random quadrilaterals: mostly rectangles and squares at any tilt, plus
  // tie-heavy grids, degenerate shapes and plain noise
  function automatic in_item_t random_quad();
    int cx[4], cy[4];
    int xv[2], yv[3];
    int perm[4];
    int a, b, m, j, tmp, kind, lo_x, hi_x, lo_y, hi_y, ox, oy;
    kind = $urandom_range(0, 99);
    // noise over every bit of every field
    if (kind < 20) return {$urandom(), $urandom(), $urandom()};
    // few distinct values, so equal y and equal x show up all the time
    if (kind < 35) begin
      xv[0] = $urandom_range(0, 4095); xv[1] = $urandom_range(0, 4095);
      yv[0] = $urandom_range(0, 4095); yv[1] = $urandom_range(0, 4095);
      yv[2] = $urandom_range(0, 4095);
      return quad(xv[$urandom_range(0, 1)], yv[$urandom_range(0, 2)],
                  xv[$urandom_range(0, 1)], yv[$urandom_range(0, 2)],
                  xv[$urandom_range(0, 1)], yv[$urandom_range(0, 2)],
                  xv[$urandom_range(0, 1)], yv[$urandom_range(0, 2)]);
    end
    // rectangle from edge u = (a, b) and v = m * (-b, a); b = 0 keeps it axis aligned
    a = int'($urandom_range(0, 1200)) - 600;
    b = ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, 1200)) - 600;
    m = $urandom_range(1, 3);
    cx[0] = 0; cx[1] = a; cx[2] = a - m * b; cx[3] = -m * b;
    cy[0] = 0; cy[1] = b; cy[2] = b + m * a; cy[3] = m * a;
    // small jitter pushes the angles around the cosine limit
    if ($urandom_range(0, 1) == 1)
      for (int k = 0; k < 4; k++) begin
        cx[k] += int'($urandom_range(0, 6)) - 3;
        cy[k] += int'($urandom_range(0, 6)) - 3;
      end
    if (kind >= 90) begin
      if (kind < 95) begin
        // repeated corner, zero length side
        cx[1] = cx[0];
        cy[1] = cy[0];
      end else begin
        // all four on one line
        for (int k = 0; k < 4; k++) begin
          cx[k] = k * a;
          cy[k] = k * b;
        end
      end
    end
    lo_x = cx[0]; hi_x = cx[0]; lo_y = cy[0]; hi_y = cy[0];
    for (int k = 1; k < 4; k++) begin
      if (cx[k] < lo_x) lo_x = cx[k];
      if (cx[k] > hi_x) hi_x = cx[k];
      if (cy[k] < lo_y) lo_y = cy[k];
      if (cy[k] > hi_y) hi_y = cy[k];
    end
    ox = int'($urandom_range(0, 4095 - (hi_x - lo_x))) - lo_x;
    oy = int'($urandom_range(0, 4095 - (hi_y - lo_y))) - lo_y;
    // shuffle the input order of the corners
    perm[0] = 0; perm[1] = 1; perm[2] = 2; perm[3] = 3;
    for (int k = 3; k > 0; k--) begin
      j       = $urandom_range(0, k);
      tmp     = perm[k];
      perm[k] = perm[j];
      perm[j] = tmp;
    end
    return quad(cx[perm[0]] + ox, cy[perm[0]] + oy, cx[perm[1]] + ox, cy[perm[1]] + oy,
                cx[perm[2]] + ox, cy[perm[2]] + oy, cx[perm[3]] + ox, cy[perm[3]] + oy);
  endfunction

  // one item: optional idle gap, then start held until the block takes it
  task automatic send_item(in_item_t it, bit may_idle);
    if (may_idle && $urandom_range(0, 99) < 9) begin
      @(negedge clk_i) start <= 1'b0;
      repeat ($urandom_range(0, 2)) @(negedge clk_i);
    end
    @(negedge clk_i);
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    board.note_item(it);
  endtask

  // stop sending and let the pipeline empty
  task automatic drain_results();
    @(negedge clk_i) start <= 1'b0;
    while (board.due_q.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 2) @(posedge clk_i);
  endtask

  // apb write or read-back, setup then access, pready honored
  task automatic apb_access(bit wr, reg_idx_e idx, logic [DATA_W-1:0] data);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= data;
    @(negedge clk_i) penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    if (wr) board.set_limit(idx, data);
    else if (prdata !== board.limit_value(idx))
      board.report($sformatf("register %s read %h expected %h", idx.name(), prdata,
                             board.limit_value(idx)));
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // new limits only with the pipeline empty, then read both back
  task automatic load_limits(logic [DATA_W-1:0] side, logic [DATA_W-1:0] cos);
    drain_results();
    apb_access(1'b1, REG_MIN_SIDE, side);
    apb_access(1'b1, REG_MAX_COS, cos);
    apb_access(1'b0, REG_MIN_SIDE, '0);
    apb_access(1'b0, REG_MAX_COS, '0);
  endtask

  // count random items; no idling inside [calm_lo, calm_hi); full drain at pause_at
  task automatic run_random(int count, int calm_lo, int calm_hi, int pause_at);
    for (int n = 0; n < count; n++) begin
      if (n == pause_at) drain_results();
      send_item(random_quad(), !(n >= calm_lo && n < calm_hi));
    end
  endtask

  // hand-picked shapes, run with the reset limits
  task automatic run_directed();
    // everything at zero and everything at full scale
    send_item(quad(0, 0, 0, 0, 0, 0, 0, 0), 1'b1);
    send_item(quad(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095), 1'b1);
    // full frame, in order and shuffled
    send_item(quad(0, 0, 4095, 0, 4095, 4095, 0, 4095), 1'b1);
    send_item(quad(4095, 4095, 0, 0, 0, 4095, 4095, 0), 1'b1);
    send_item(quad(0, 4095, 4095, 4095, 0, 0, 4095, 0), 1'b1);
    // side exactly at the threshold fails, one pixel more passes
    send_item(quad(100, 100, 250, 100, 250, 250, 100, 250), 1'b1);
    send_item(quad(100, 100, 251, 100, 251, 251, 100, 251), 1'b1);
    // all y equal: first two indices become the bottom pair
    send_item(quad(10, 500, 900, 500, 300, 500, 4000, 500), 1'b1);
    // all x equal: first of each pair is left
    send_item(quad(700, 10, 700, 3000, 700, 2000, 700, 40), 1'b1);
    // three-way tie on the largest y
    send_item(quad(5, 900, 800, 900, 400, 900, 50, 100), 1'b1);
    // tie on the second largest y only
    send_item(quad(300, 100, 900, 2000, 100, 2000, 1500, 3000), 1'b1);
    // equal x inside the bottom pair and inside the top pair
    send_item(quad(700, 100, 700, 200, 1200, 3000, 1200, 2900), 1'b1);
    // diamond: square tilted 45 degrees, two corners share the same y
    send_item(quad(2000, 1000, 3000, 2000, 2000, 3000, 1000, 2000), 1'b1);
    // repeated corner gives a zero length side
    send_item(quad(100, 100, 100, 100, 900, 900, 100, 900), 1'b1);
    // collinear corners
    send_item(quad(0, 0, 1000, 1000, 2000, 2000, 3000, 3000), 1'b1);
    // strong skew fails the angle test
    send_item(quad(0, 0, 1000, 0, 1500, 1000, 500, 1000), 1'b1);
    // skew just inside and just outside the cosine limit
    send_item(quad(0, 0, 1000, 0, 1300, 954, 300, 954), 1'b1);
    send_item(quad(0, 0, 1000, 0, 1300, 953, 300, 953), 1'b1);
    // trapezoid
    send_item(quad(1000, 500, 3000, 500, 3500, 2500, 500, 2500), 1'b1);
    // alternating bit patterns in every field
    send_item(quad(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hAAA, 12'hAAA, 12'h555, 12'h555),
              1'b1);
    // nearly full frame with one corner pulled in by a pixel
    send_item(quad(0, 0, 4095, 0, 4095, 4095, 1, 4095), 1'b1);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    @(negedge clk_i) rst_ni <= 1'b1;

    // reset values of both limits
    apb_access(1'b0, REG_MIN_SIDE, '0);
    apb_access(1'b0, REG_MAX_COS, '0);

    run_directed();
    run_random(200, 40, 160, 180);

    // zero limits: any nonzero side passes, no corner passes
    load_limits(32'd0, 32'd0);
    run_random(100, 0, 0, -1);

    // largest in-range limits: no side can exceed the threshold
    load_limits(32'd33538050, 32'd65536);
    run_random(80, 0, 0, -1);

    // all ones written, only the low bits survive; collinear corners pass the angle test
    load_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    run_random(80, 0, 0, -1);

    // sides unchecked, widest angle window
    load_limits(32'd0, 32'd65536);
    run_random(100, 0, 0, -1);

    // a few random settings, one with a full drain in the middle
    load_limits($urandom_range(0, 60000), $urandom_range(1, 65536));
    run_random(100, 0, 0, 50);
    load_limits($urandom_range(0, 60000), $urandom_range(1, 65536));
    run_random(100, 0, 0, -1);
    load_limits($urandom_range(0, 60000), $urandom_range(1, 65536));
    run_random(100, 0, 0, -1);

    drain_results();
    board.finish_check();
    if (board.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### quad_corner_sort_and_square_test.f
rtl/qcs_pkg.sv
rtl/qcs_cfg.sv
rtl/qcs_sort.sv
rtl/qcs_geom.sv
rtl/qcs_cmp.sv
rtl/quad_corner_sort_and_square_test.sv
test/quad_corner_sort_and_square_test_tb.sv
